[rtl/core/audio_stream_endpoint_fsm_macros.svh]
// Assertion macros for the audio stream endpoint.
`ifndef AUDIO_STREAM_ENDPOINT_FSM_MACROS_SVH
`define AUDIO_STREAM_ENDPOINT_FSM_MACROS_SVH

`ifndef ASSERT_OFF

// Implication checked on every rising clock edge outside reset.
`define ASE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define ASE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASE_ASSERT_IMP(label, ante, cons, msg)
`define ASE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/core/ase_fsm_pkg.sv]
// Types and codes shared by the audio stream endpoint files.
package ase_fsm_pkg;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_CODEC     = 3'd1,
        ST_QOS       = 3'd2,
        ST_ENABLING  = 3'd3,
        ST_DISABLING = 3'd4,
        ST_STREAMING = 3'd5,
        ST_RELEASING = 3'd6
    } ase_state_t;

    typedef enum logic [3:0] {
        EV_CFG_CODEC    = 4'd0,
        EV_CFG_QOS      = 4'd1,
        EV_ENABLE       = 4'd2,
        EV_RX_START     = 4'd3,
        EV_DISABLE      = 4'd4,
        EV_RX_STOP      = 4'd5,
        EV_METADATA     = 4'd6,
        EV_RELEASE      = 4'd7,
        EV_CIS_LOST     = 4'd8,
        EV_CIS_ASSIGNED = 4'd9,
        EV_VALIDATE     = 4'd10
    } ase_event_t;

    typedef struct packed {
        logic       handled;
        ase_state_t ase_state;
        logic       notify;
        logic       codec_present;
        logic       qos_present;
        logic       path_present;
        logic       metadata_present;
        logic       last;
    } ase_result_t;

endpackage

[rtl/core/ase_cmd_if.sv]
// Handshake channel that carries one event item into the endpoint.
interface ase_cmd_if;
    logic       valid;
    logic       ready;
    logic [3:0] command;
    logic       keep_codec;

    modport source (output valid, output command, output keep_codec, input ready);
    modport sink (input valid, input command, input keep_codec, output ready);
endinterface

[rtl/core/ase_res_if.sv]
// Handshake channel that carries one result item out of the endpoint.
interface ase_res_if;
    logic       valid;
    logic       ready;
    logic       handled;
    logic [2:0] ase_state;
    logic       notify;
    logic       codec_present;
    logic       qos_present;
    logic       path_present;
    logic       metadata_present;
    logic       last;

    modport source (
        output valid, output handled, output ase_state, output notify,
        output codec_present, output qos_present, output path_present,
        output metadata_present, output last, input ready
    );
    modport sink (
        input valid, input handled, input ase_state, input notify,
        input codec_present, input qos_present, input path_present,
        input metadata_present, input last, output ready
    );
endinterface

[rtl/core/audio_stream_endpoint_fsm.sv]
// Audio stream endpoint state machine with registered result output.
//
//   channel   dir  handshake          payload
//   cmd       in   valid / ready      command[3:0], keep_codec
//   res       out  valid / ready      handled, ase_state[2:0], notify, four flags, last
//   cfg       in   cfg_wen            cfg_wdata (is_source)
//
// An event is decoded and the endpoint state updated in the cycle it is accepted;
// its result appears on res in the next cycle. One event per cycle is taken
// while cmd.ready is high. A release produces two result items and holds cmd.ready
// low while the second item waits in pend_reg behind the first in the output register.
// The output register frees itself in the cycle its item is taken, so a stalled
// res side stops cmd only while a result is still waiting. Reset returns to idle
// with all flags clear and is_source at zero.
`include "audio_stream_endpoint_fsm_macros.svh"

module audio_stream_endpoint_fsm (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wen,
    input  logic          cfg_wdata,
    ase_cmd_if.sink       cmd,
    ase_res_if.source     res
);
    import ase_fsm_pkg::*;

    logic        is_source_reg;
    ase_state_t  state_reg;
    ase_state_t  state_next;
    logic        codec_reg;
    logic        qos_reg;
    logic        path_reg;
    logic        meta_reg;
    logic        codec_next;
    logic        qos_next;
    logic        path_next;
    logic        meta_next;

    ase_result_t out_reg;
    logic        out_valid_reg;
    ase_result_t pend_reg;
    logic        pend_valid_reg;

    ase_result_t first_res;
    ase_result_t second_res;
    ase_event_t  ev;
    ase_state_t  dest;
    logic        go;
    logic        acc;
    logic        rel;
    logic        in_fire;

    assign cmd.ready = !pend_valid_reg && (!out_valid_reg || res.ready);
    assign in_fire   = cmd.valid && cmd.ready;

    always_comb
    begin
        ev         = ase_event_t'(cmd.command);
        go         = 1'b0;
        acc        = 1'b0;
        rel        = 1'b0;
        dest       = state_reg;
        codec_next = codec_reg;
        qos_next   = qos_reg;
        path_next  = path_reg;
        meta_next  = meta_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (ev == EV_CFG_CODEC)
                begin
                    codec_next = 1'b1;
                    go         = 1'b1;
                    dest       = ST_CODEC;
                end
            end
            ST_CODEC:
            begin
                if (ev == EV_CFG_CODEC)
                begin
                    codec_next = 1'b1;
                    go         = 1'b1;
                    dest       = ST_CODEC;
                end
                else if (ev == EV_CFG_QOS)
                begin
                    qos_next  = 1'b1;
                    path_next = 1'b1;
                    go        = 1'b1;
                    dest      = ST_QOS;
                end
                else if (ev == EV_RELEASE)
                begin
                    rel = 1'b1;
                end
            end
            ST_QOS:
            begin
                if (ev == EV_CFG_CODEC)
                begin
                    qos_next   = 1'b0;
                    codec_next = 1'b1;
                    go         = 1'b1;
                    dest       = ST_CODEC;
                end
                else if (ev == EV_CFG_QOS)
                begin
                    qos_next  = 1'b1;
                    path_next = 1'b1;
                    go        = 1'b1;
                    dest      = ST_QOS;
                end
                else if (ev == EV_ENABLE)
                begin
                    meta_next = 1'b1;
                    go        = 1'b1;
                    dest      = ST_ENABLING;
                end
                else if (ev == EV_RELEASE)
                begin
                    rel = 1'b1;
                end
                else if (ev == EV_CIS_LOST || ev == EV_VALIDATE)
                begin
                    acc = 1'b1;
                end
            end
            ST_ENABLING, ST_STREAMING:
            begin
                if (ev == EV_DISABLE)
                begin
                    go   = 1'b1;
                    dest = is_source_reg ? ST_DISABLING : ST_QOS;
                end
                else if (ev == EV_METADATA)
                begin
                    meta_next = 1'b1;
                    go        = 1'b1;
                    dest      = state_reg;
                end
                else if (ev == EV_CIS_LOST)
                begin
                    go   = 1'b1;
                    dest = ST_QOS;
                end
                else if (ev == EV_RELEASE)
                begin
                    rel = 1'b1;
                end
                else if (state_reg == ST_ENABLING && ev == EV_RX_START)
                begin
                    go   = 1'b1;
                    dest = ST_STREAMING;
                end
                else if (state_reg == ST_ENABLING && ev == EV_CIS_ASSIGNED)
                begin
                    acc = 1'b1;
                end
            end
            ST_DISABLING:
            begin
                if (ev == EV_RX_STOP || ev == EV_CIS_LOST)
                begin
                    go   = 1'b1;
                    dest = ST_QOS;
                end
                else if (ev == EV_RELEASE)
                begin
                    rel = 1'b1;
                end
            end
            default:
            begin
                go = 1'b0;
            end
        endcase

        // Leaving disabling drops the data path; entering QoS configured drops metadata.
        if (go)
        begin
            if (state_reg == ST_DISABLING)
            begin
                path_next = 1'b0;
            end
            if (dest == ST_QOS)
            begin
                meta_next = 1'b0;
            end
        end

        // Release passes through releasing and lands at once in its final state.
        if (rel)
        begin
            if (!cmd.keep_codec)
            begin
                codec_next = 1'b0;
            end
            qos_next  = 1'b0;
            path_next = 1'b0;
            meta_next = 1'b0;
            dest      = codec_next ? ST_CODEC : ST_IDLE;
        end

        state_next = (go || rel) ? dest : state_reg;

        first_res.handled          = go || acc || rel;
        first_res.ase_state        = rel ? ST_RELEASING : state_next;
        first_res.notify           = go || rel;
        first_res.codec_present    = codec_next;
        first_res.qos_present      = qos_next;
        first_res.path_present     = path_next;
        first_res.metadata_present = meta_next;
        first_res.last             = !rel;

        second_res.handled          = 1'b1;
        second_res.ase_state        = dest;
        second_res.notify           = 1'b1;
        second_res.codec_present    = codec_next;
        second_res.qos_present      = qos_next;
        second_res.path_present     = path_next;
        second_res.metadata_present = meta_next;
        second_res.last             = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_source_reg  <= 1'b0;
            state_reg      <= ST_IDLE;
            codec_reg      <= 1'b0;
            qos_reg        <= 1'b0;
            path_reg       <= 1'b0;
            meta_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_reg        <= '0;
            pend_reg       <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                is_source_reg <= cfg_wdata;
            end

            if (in_fire)
            begin
                state_reg      <= state_next;
                codec_reg      <= codec_next;
                qos_reg        <= qos_next;
                path_reg       <= path_next;
                meta_reg       <= meta_next;
                out_reg        <= first_res;
                out_valid_reg  <= 1'b1;
                pend_reg       <= second_res;
                pend_valid_reg <= rel;
            end
            else if (out_valid_reg && res.ready)
            begin
                if (pend_valid_reg)
                begin
                    out_reg        <= pend_reg;
                    pend_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.handled          = out_reg.handled;
    assign res.ase_state        = out_reg.ase_state;
    assign res.notify           = out_reg.notify;
    assign res.codec_present    = out_reg.codec_present;
    assign res.qos_present      = out_reg.qos_present;
    assign res.path_present     = out_reg.path_present;
    assign res.metadata_present = out_reg.metadata_present;
    assign res.last             = out_reg.last;

    `ASE_ASSERT_IMP(a_pend_behind_out, pend_valid_reg, out_valid_reg, "pending item without output item")
    `ASE_ASSERT_IMP(a_not_last_has_pend, out_valid_reg && !out_reg.last, pend_valid_reg, "first release item without its second")
    `ASE_ASSERT_IMP(a_pend_final_state, pend_valid_reg, pend_reg.last && (pend_reg.ase_state == ST_CODEC || pend_reg.ase_state == ST_IDLE), "bad second release item")
    `ASE_ASSERT_NEXT(a_release_queues_two, in_fire && rel, pend_valid_reg && out_valid_reg, "release did not queue two items")
    `ASE_ASSERT_IMP(a_no_held_releasing, 1'b1, state_reg != ST_RELEASING, "releasing state was kept")

endmodule

[tb/tb_audio_stream_endpoint_fsm.sv]
// Self-checking testbench for the audio stream endpoint state machine.
`timescale 1ns / 100ps

module tb_audio_stream_endpoint_fsm;

    import ase_fsm_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PRINT_LIMIT  = 50;
    localparam int PHASE_EVENTS = 220;

    logic clk;
    logic rst_n;
    logic cfg_wen;
    logic cfg_wdata;

    ase_cmd_if cmd_ch ();
    ase_res_if res_ch ();

    audio_stream_endpoint_fsm DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // Endpoint state as the checker expects it to be.
    ase_state_t  ep_state;
    logic        codec_held;
    logic        qos_held;
    logic        path_held;
    logic        meta_held;
    logic        source_mode;

    ase_result_t expected_results[$];

    int error_count;
    int cycle_count;
    int src_idle_mode;
    int sink_idle_mode;
    int sink_stall_left;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Mode 0 never idles, mode 1 idles now and then, mode 2 idles often and long.
    function automatic int pick_idle(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
        begin
            if (r < 60)
                return 0;
            if (r < 92)
                return $urandom_range(1, 3);
            return $urandom_range(8, 30);
        end
        if (r < 25)
            return 0;
        if (r < 75)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic ase_result_t build_result(input logic handled, input logic notify,
                                                 input logic last);
        ase_result_t r;
        r.handled          = handled;
        r.ase_state        = ep_state;
        r.notify           = notify;
        r.codec_present    = codec_held;
        r.qos_present      = qos_held;
        r.path_present     = path_held;
        r.metadata_present = meta_held;
        r.last             = last;
        return r;
    endfunction

    function automatic void move_to(input ase_state_t dest);
        if (ep_state == ST_DISABLING)
            path_held = 1'b0;
        ep_state = dest;
        if (dest == ST_QOS)
            meta_held = 1'b0;
        if (dest == ST_RELEASING)
        begin
            path_held = 1'b0;
            meta_held = 1'b0;
            qos_held  = 1'b0;
        end
    endfunction

    // Applies one accepted event and queues the result items it must produce.
    function automatic void predict_event(input logic [3:0] code, input logic keep);
        ase_state_t from;
        ase_state_t dest;
        bit         moves;
        bit         accepted;
        bit         release_req;
        from        = ep_state;
        dest        = ep_state;
        moves       = 1'b0;
        accepted    = 1'b0;
        release_req = 1'b0;
        case (from)
            ST_IDLE:
                if (code == EV_CFG_CODEC)
                begin
                    codec_held = 1'b1;
                    dest = ST_CODEC;
                    moves = 1'b1;
                end
            ST_CODEC:
                if (code == EV_CFG_CODEC)
                begin
                    codec_held = 1'b1;
                    dest = ST_CODEC;
                    moves = 1'b1;
                end
                else if (code == EV_CFG_QOS)
                begin
                    qos_held = 1'b1;
                    path_held = 1'b1;
                    dest = ST_QOS;
                    moves = 1'b1;
                end
                else if (code == EV_RELEASE)
                    release_req = 1'b1;
            ST_QOS:
                if (code == EV_CFG_CODEC)
                begin
                    qos_held = 1'b0;
                    codec_held = 1'b1;
                    dest = ST_CODEC;
                    moves = 1'b1;
                end
                else if (code == EV_CFG_QOS)
                begin
                    qos_held = 1'b1;
                    path_held = 1'b1;
                    dest = ST_QOS;
                    moves = 1'b1;
                end
                else if (code == EV_ENABLE)
                begin
                    meta_held = 1'b1;
                    dest = ST_ENABLING;
                    moves = 1'b1;
                end
                else if (code == EV_RELEASE)
                    release_req = 1'b1;
                else if (code == EV_CIS_LOST || code == EV_VALIDATE)
                    accepted = 1'b1;
            ST_ENABLING, ST_STREAMING:
                if (code == EV_DISABLE)
                begin
                    if (source_mode)
                        dest = ST_DISABLING;
                    else
                        dest = ST_QOS;
                    moves = 1'b1;
                end
                else if (code == EV_METADATA)
                begin
                    meta_held = 1'b1;
                    dest = from;
                    moves = 1'b1;
                end
                else if (code == EV_CIS_LOST)
                begin
                    dest = ST_QOS;
                    moves = 1'b1;
                end
                else if (code == EV_RELEASE)
                    release_req = 1'b1;
                else if (from == ST_ENABLING && code == EV_RX_START)
                begin
                    dest = ST_STREAMING;
                    moves = 1'b1;
                end
                else if (from == ST_ENABLING && code == EV_CIS_ASSIGNED)
                    accepted = 1'b1;
            ST_DISABLING:
                if (code == EV_RX_STOP || code == EV_CIS_LOST)
                begin
                    dest = ST_QOS;
                    moves = 1'b1;
                end
                else if (code == EV_RELEASE)
                    release_req = 1'b1;
            default:
                ;
        endcase

        if (release_req)
        begin
            if (!keep)
                codec_held = 1'b0;
            move_to(ST_RELEASING);
            expected_results.push_back(build_result(1'b1, 1'b1, 1'b0));
            if (codec_held)
                move_to(ST_CODEC);
            else
                move_to(ST_IDLE);
            expected_results.push_back(build_result(1'b1, 1'b1, 1'b1));
        end
        else if (moves)
        begin
            move_to(dest);
            expected_results.push_back(build_result(1'b1, 1'b1, 1'b1));
        end
        else
        begin
            expected_results.push_back(build_result(accepted, 1'b0, 1'b1));
        end
    endfunction

    // Entered and left at a falling edge; valid stays high when no gap follows.
    task automatic send_event(input logic [3:0] code, input logic keep);
        int gap;
        cmd_ch.valid      = 1'b1;
        cmd_ch.command    = code;
        cmd_ch.keep_codec = keep;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        predict_event(code, keep);
        @(negedge clk);
        gap = pick_idle(src_idle_mode);
        if (gap > 0)
        begin
            cmd_ch.valid      = 1'b0;
            cmd_ch.command    = 4'($urandom_range(0, 15));
            cmd_ch.keep_codec = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        cmd_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_source(input logic value);
        drain_results();
        cfg_wen   = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wen     = 1'b0;
        source_mode = value;
    endtask

    // Mostly commands the current state accepts, with some noise mixed in.
    function automatic logic [3:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        case (ep_state)
            ST_IDLE:
                return EV_CFG_CODEC;
            ST_CODEC:
                if (r < 10)
                    return EV_CFG_CODEC;
                else if (r < 90)
                    return EV_CFG_QOS;
                else
                    return EV_RELEASE;
            ST_QOS:
                if (r < 8)
                    return EV_CFG_CODEC;
                else if (r < 16)
                    return EV_CFG_QOS;
                else if (r < 76)
                    return EV_ENABLE;
                else if (r < 84)
                    return EV_RELEASE;
                else if (r < 92)
                    return EV_CIS_LOST;
                else
                    return EV_VALIDATE;
            ST_ENABLING:
                if (r < 15)
                    return EV_DISABLE;
                else if (r < 30)
                    return EV_METADATA;
                else if (r < 40)
                    return EV_CIS_LOST;
                else if (r < 48)
                    return EV_RELEASE;
                else if (r < 85)
                    return EV_RX_START;
                else
                    return EV_CIS_ASSIGNED;
            ST_STREAMING:
                if (r < 30)
                    return EV_DISABLE;
                else if (r < 60)
                    return EV_METADATA;
                else if (r < 80)
                    return EV_CIS_LOST;
                else
                    return EV_RELEASE;
            ST_DISABLING:
                if (r < 50)
                    return EV_RX_STOP;
                else if (r < 80)
                    return EV_CIS_LOST;
                else
                    return EV_RELEASE;
            default:
                return 4'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic test_ignored_in_idle();
        send_event(EV_RELEASE, 1'b1);
        send_event(EV_DISABLE, 1'b0);
        send_event(4'd15, 1'b1);
    endtask

    task automatic test_sink_lifecycle();
        send_event(EV_CFG_CODEC, 1'b0);
        send_event(EV_CFG_CODEC, 1'b1);
        send_event(EV_CFG_QOS, 1'b0);
        send_event(EV_VALIDATE, 1'b0);
        send_event(EV_CIS_LOST, 1'b0);
        send_event(EV_CFG_CODEC, 1'b0);
        send_event(EV_CFG_QOS, 1'b0);
        send_event(EV_ENABLE, 1'b0);
        send_event(EV_CIS_ASSIGNED, 1'b0);
        send_event(EV_METADATA, 1'b0);
        send_event(EV_RX_START, 1'b0);
        send_event(EV_METADATA, 1'b1);
        send_event(EV_DISABLE, 1'b0);
        send_event(EV_RELEASE, 1'b1);
    endtask

    task automatic test_source_disable();
        set_source(1'b1);
        send_event(EV_CFG_QOS, 1'b0);
        send_event(EV_ENABLE, 1'b0);
        send_event(EV_DISABLE, 1'b0);
        send_event(EV_RX_STOP, 1'b0);
        send_event(EV_ENABLE, 1'b0);
        send_event(EV_RX_START, 1'b0);
        send_event(EV_DISABLE, 1'b0);
        send_event(EV_CIS_LOST, 1'b0);
        send_event(EV_ENABLE, 1'b0);
        send_event(EV_DISABLE, 1'b0);
        send_event(EV_RELEASE, 1'b0);
    endtask

    task automatic test_random_traffic(input logic source, input int src_mode,
                                       input int sink_mode);
        int sent_count;
        sent_count = 0;
        set_source(source);
        src_idle_mode  = src_mode;
        sink_idle_mode = sink_mode;
        while (sent_count < PHASE_EVENTS)
        begin
            send_event(pick_command(), 1'($urandom_range(0, 1)));
            sent_count++;
        end
    endtask

    // Result side: random back-pressure, one item checked per handshake.
    initial
    begin
        res_ch.ready    = 1'b0;
        sink_stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (sink_stall_left > 0)
            begin
                res_ch.ready = 1'b0;
                sink_stall_left--;
            end
            else
            begin
                res_ch.ready    = 1'b1;
                sink_stall_left = pick_idle(sink_idle_mode);
            end
        end
    end

    task automatic check_field(input string name, input logic [2:0] got,
                               input logic [2:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin
        ase_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result item with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                check_field("handled", res_ch.handled, want.handled);
                check_field("ase_state", res_ch.ase_state, want.ase_state);
                check_field("notify", res_ch.notify, want.notify);
                check_field("codec_present", res_ch.codec_present, want.codec_present);
                check_field("qos_present", res_ch.qos_present, want.qos_present);
                check_field("path_present", res_ch.path_present, want.path_present);
                check_field("metadata_present", res_ch.metadata_present,
                            want.metadata_present);
                check_field("last", res_ch.last, want.last);
            end
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_wen           = 1'b0;
        cfg_wdata         = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = 4'd0;
        cmd_ch.keep_codec = 1'b0;
        ep_state          = ST_IDLE;
        codec_held        = 1'b0;
        qos_held          = 1'b0;
        path_held         = 1'b0;
        meta_held         = 1'b0;
        source_mode       = 1'b0;
        error_count       = 0;
        cycle_count       = 0;
        src_idle_mode     = 1;
        sink_idle_mode    = 1;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_ignored_in_idle();
        test_sink_lifecycle();
        test_source_disable();
        test_random_traffic(1'b0, 0, 0);
        test_random_traffic(1'b1, 1, 1);
        test_random_traffic(1'($urandom_range(0, 1)), 1, 2);
        test_random_traffic(1'b1, 2, 1);
        test_random_traffic(1'b0, 1, 0);
        test_random_traffic(1'($urandom_range(0, 1)), 0, 1);

        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[audio_stream_endpoint_fsm.f]
+incdir+rtl/core
rtl/core/ase_fsm_pkg.sv
rtl/core/ase_cmd_if.sv
rtl/core/ase_res_if.sv
rtl/core/audio_stream_endpoint_fsm.sv
tb/tb_audio_stream_endpoint_fsm.sv
